// ----- rtl/sgb_pkg.sv -----
// Shared types, constants and helpers for the scaled glyph text blitter.
// No dependencies; imported by every module of the block.
`default_nettype none

package sgb_pkg;

	localparam int MAX_GLYPH_DIM = 8;
	localparam int GLYPH_COUNT   = 95;
	localparam int MAX_FRAME_DIM = 4096;
	localparam int FONT_DEPTH    = MAX_GLYPH_DIM * MAX_GLYPH_DIM * GLYPH_COUNT;
	localparam int FONT_AW       = $clog2(FONT_DEPTH);

	// item kinds
	localparam logic [1:0] KIND_FONT  = 2'd0;
	localparam logic [1:0] KIND_CHAR  = 2'd1;
	localparam logic [1:0] KIND_START = 2'd2;

	// character codes
	localparam logic [7:0] NEWLINE_CODE    = 8'd10;
	localparam logic [7:0] FIRST_PRINTABLE = 8'd32;
	localparam logic [7:0] LAST_PRINTABLE  = 8'd126;

	// register indexes
	localparam logic [2:0] REG_GLYPH_W  = 3'd0;
	localparam logic [2:0] REG_GLYPH_H  = 3'd1;
	localparam logic [2:0] REG_CELL_W   = 3'd2;
	localparam logic [2:0] REG_CELL_H   = 3'd3;
	localparam logic [2:0] REG_ORIGIN_X = 3'd4;
	localparam logic [2:0] REG_ORIGIN_Y = 3'd5;
	localparam logic [2:0] REG_TARGET_W = 3'd6;
	localparam logic [2:0] REG_TARGET_H = 3'd7;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  char_code;
		logic [12:0] font_index;
		logic [31:0] font_pixel;
	} item_t;

	typedef struct packed {
		logic [23:0] frame_address;
		logic [31:0] pixel_value;
		logic        last_write;
	} pix_t;

	// saturated configuration, as the walker sees it
	typedef struct packed {
		logic [3:0]  gw;
		logic [3:0]  gh;
		logic [3:0]  cw;
		logic [3:0]  ch;
		logic [11:0] ox;
		logic [11:0] oy;
		logic [12:0] tw;
		logic [12:0] th;
	} cfg_t;

	// decoded item commands into the walker
	typedef struct packed {
		logic       home;
		logic       newline;
		logic       draw;
		logic [6:0] glyph;
	} cmd_t;

	// font read request out of the walker
	typedef struct packed {
		logic              valid;
		logic [FONT_AW-1:0] src;
		logic [23:0]       frame;
		logic              last;
	} req_t;

	function automatic logic [3:0] clamp_dim(input logic [3:0] v);
		logic [3:0] r;
		r = v;
		if (v == 4'd0)
			r = 4'd1;
		else if (v > 4'(MAX_GLYPH_DIM))
			r = 4'(MAX_GLYPH_DIM);
		return r;
	endfunction

	function automatic logic [12:0] clamp_frame(input logic [12:0] v);
		return (v > 13'(MAX_FRAME_DIM)) ? 13'(MAX_FRAME_DIM) : v;
	endfunction

	// floor(g*i/c) for i < c, so the quotient stays below 8: three restoring steps
	function automatic logic [2:0] scale_idx(input logic [3:0] g, input logic [3:0] i,
			input logic [3:0] c);
		logic [6:0] n;
		logic [6:0] d;
		logic [2:0] q;
		n = {3'b0, g} * {3'b0, i};
		q = '0;
		for (int b = 2; b >= 0; b--) begin
			d = {3'b0, c} << b;
			if (n >= d) begin
				n = n - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/sgb_font_mem.sv -----
// Font store: single-port-write, single-port-read synchronous RAM, registered read.
// Depends on sgb_pkg for depth and address width.
`default_nettype none

module sgb_font_mem (
	input  wire logic                       clk,
	input  wire logic                       wr_en,
	input  wire logic [sgb_pkg::FONT_AW-1:0] wr_addr,
	input  wire logic [31:0]                wr_data,
	input  wire logic                       rd_en,
	input  wire logic [sgb_pkg::FONT_AW-1:0] rd_addr,
	output logic      [31:0]                rd_data
);
	import sgb_pkg::*;

	logic [31:0] mem [FONT_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

// ----- rtl/sgb_walk.sv -----
// Text cursor and cell walker: sets up one character's cell, then steps
// through its visible pixels, one font read request per cycle while issue_ok is high.
// Depends on sgb_pkg.
`default_nettype none

module sgb_walk (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire sgb_pkg::cfg_t cfg,
	input  wire sgb_pkg::cmd_t cmd,
	input  wire logic          issue_ok,
	output logic               idle,
	output sgb_pkg::req_t      req
);
	import sgb_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SETUP = 3'b010,
		ST_RUN   = 3'b100
	} state_t;

	state_t      state_q;
	logic [11:0] col_q;
	logic [11:0] row_q;
	logic [16:0] base_x_q;
	logic [16:0] base_y_q;
	logic [6:0]  glyph_q;
	logic [3:0]  nx_q;
	logic [3:0]  ny_q;
	logic [2:0]  ix_q;
	logic [2:0]  iy_q;
	logic [23:0] row_addr_q;
	logic [9:0]  glyph_off_q;
	logic [9:0]  stride_q;

	logic [16:0] span_x;
	logic [16:0] span_y;
	logic [3:0]  nx;
	logic [3:0]  ny;
	logic [2:0]  sx;
	logic [2:0]  sy;
	logic        last_col;
	logic        last_row;
	logic        fire;

	// visible columns and rows of the cell: clipping only trims the far edges
	always_comb begin
		span_x = {4'b0, cfg.tw} - base_x_q;
		span_y = {4'b0, cfg.th} - base_y_q;
		if (base_x_q >= {4'b0, cfg.tw})
			nx = '0;
		else if (span_x >= {13'b0, cfg.cw})
			nx = cfg.cw;
		else
			nx = span_x[3:0];
		if (base_y_q >= {4'b0, cfg.th})
			ny = '0;
		else if (span_y >= {13'b0, cfg.ch})
			ny = cfg.ch;
		else
			ny = span_y[3:0];
	end

	assign sx       = scale_idx(cfg.gw, {1'b0, ix_q}, cfg.cw);
	assign sy       = scale_idx(cfg.gh, {1'b0, iy_q}, cfg.ch);
	assign last_col = ({1'b0, ix_q} == nx_q - 4'd1);
	assign last_row = ({1'b0, iy_q} == ny_q - 4'd1);
	assign fire     = (state_q == ST_RUN) && issue_ok;
	assign idle     = (state_q == ST_IDLE);

	always_comb begin
		req.valid = fire;
		req.src   = 13'({10'b0, sy} * {3'b0, stride_q}) + {3'b0, glyph_off_q} + {10'b0, sx};
		req.frame = row_addr_q + {21'b0, ix_q};
		req.last  = last_col && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			ix_q    <= '0;
			iy_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.home) begin
						col_q <= '0;
						row_q <= '0;
					end else if (cmd.newline) begin
						col_q <= '0;
						row_q <= row_q + 12'd1;
					end else if (cmd.draw) begin
						col_q   <= col_q + 12'd1;
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					ix_q <= '0;
					iy_q <= '0;
					if (nx == 4'd0 || ny == 4'd0)
						state_q <= ST_IDLE;
					else
						state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (fire) begin
						if (last_col) begin
							ix_q <= '0;
							iy_q <= iy_q + 3'd1;
							if (last_row)
								state_q <= ST_IDLE;
						end else begin
							ix_q <= ix_q + 3'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (idle && cmd.draw && !cmd.home && !cmd.newline) begin
			base_x_q <= {5'b0, cfg.ox} + {5'b0, col_q} * {13'b0, cfg.cw};
			base_y_q <= {5'b0, cfg.oy} + {5'b0, row_q} * {13'b0, cfg.ch};
			glyph_q  <= cmd.glyph;
		end
		if (state_q == ST_SETUP) begin
			nx_q        <= nx;
			ny_q        <= ny;
			row_addr_q  <= {11'b0, cfg.tw} * {12'b0, base_y_q[11:0]}
				+ {12'b0, base_x_q[11:0]};
			glyph_off_q <= {6'b0, cfg.gw} * {3'b0, glyph_q};
			stride_q    <= 10'(GLYPH_COUNT) * {6'b0, cfg.gw};
		end else if (fire && last_col) begin
			row_addr_q <= row_addr_q + {11'b0, cfg.tw};
		end
	end

endmodule

`default_nettype wire

// ----- rtl/scaled_glyph_text_blitter.sv -----
// Top level of the scaled glyph text blitter: config registers, item decode,
// font store, cell walker and output queue. Depends on sgb_pkg, sgb_font_mem, sgb_walk.
//
// Usage:
//  - cfg channel: one beat writes register cfg_index with cfg_data (low bits used).
//    Always ready. Write only while the block is idle.
//  - item channel: kind 0 loads one font store word (index past the store is dropped),
//    kind 2 homes the cursor, kind 1 is a character: newline moves to the next text
//    row, codes 32..126 draw a scaled glyph cell, other codes and kind 3 do nothing.
//  - pix channel: one beat per visible cell pixel, row-major, last_write on the
//    final beat of a character. A fully clipped character gives no beats.
// Flow: items other than a drawn character leave item_ready high. A drawn character
//  holds item_ready low through its setup and its visible pixels (up to 64); the walker
//  issues one font store read per cycle unless the credit check holds it, so the single
//  read port sets the rate.
// Pipeline: a first pixel beat passes setup, the font read register and the queue.
// Stall: a two-entry output queue with a credit check on reads in flight; when the
//  receiver stalls, the walker simply waits, nothing is dropped.
// Reset: registers return to 8,8,8,8,0,0,640,480, cursor to 0,0, queue empty.
//  The font store is not cleared; load it before drawing.
`default_nettype none

module scaled_glyph_text_blitter (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_valid,
	output logic                cfg_ready,
	input  wire logic [2:0]     cfg_index,
	input  wire logic [12:0]    cfg_data,
	input  wire logic           item_valid,
	output logic                item_ready,
	input  wire sgb_pkg::item_t item,
	output logic                pix_valid,
	input  wire logic           pix_ready,
	output sgb_pkg::pix_t       pix
);
	import sgb_pkg::*;

	// raw configuration registers
	logic [3:0]  glyph_w_q;
	logic [3:0]  glyph_h_q;
	logic [3:0]  cell_w_q;
	logic [3:0]  cell_h_q;
	logic [11:0] origin_x_q;
	logic [11:0] origin_y_q;
	logic [12:0] target_w_q;
	logic [12:0] target_h_q;

	cfg_t  cfg;
	cmd_t  cmd;
	req_t  req;
	logic  walk_idle;
	logic  issue_ok;
	logic  item_beat;
	logic  font_wr;
	logic  printable;

	// read in flight (data lands from the font store in the same cycle)
	logic        rd_valid_s1;
	logic [23:0] frame_s1;
	logic        last_s1;
	logic [31:0] rd_data;

	// output queue, entry 0 is the head
	logic [1:0] q_valid_q;
	pix_t       q_head_q;
	pix_t       q_tail_q;
	pix_t       q_new;
	logic       pop;
	logic [2:0] occupancy;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_w_q  <= 4'd8;
			glyph_h_q  <= 4'd8;
			cell_w_q   <= 4'd8;
			cell_h_q   <= 4'd8;
			origin_x_q <= '0;
			origin_y_q <= '0;
			target_w_q <= 13'd640;
			target_h_q <= 13'd480;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GLYPH_W:  glyph_w_q  <= cfg_data[3:0];
				REG_GLYPH_H:  glyph_h_q  <= cfg_data[3:0];
				REG_CELL_W:   cell_w_q   <= cfg_data[3:0];
				REG_CELL_H:   cell_h_q   <= cfg_data[3:0];
				REG_ORIGIN_X: origin_x_q <= cfg_data[11:0];
				REG_ORIGIN_Y: origin_y_q <= cfg_data[11:0];
				REG_TARGET_W: target_w_q <= cfg_data;
				REG_TARGET_H: target_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// saturate sizes once here; the walker only sees legal values
	always_comb begin
		cfg.gw = clamp_dim(glyph_w_q);
		cfg.gh = clamp_dim(glyph_h_q);
		cfg.cw = clamp_dim(cell_w_q);
		cfg.ch = clamp_dim(cell_h_q);
		cfg.ox = origin_x_q;
		cfg.oy = origin_y_q;
		cfg.tw = clamp_frame(target_w_q);
		cfg.th = clamp_frame(target_h_q);
	end

	// item decode; the walker is idle whenever an item is taken
	assign item_ready = walk_idle;
	assign item_beat  = item_valid && item_ready;
	assign printable  = (item.char_code >= FIRST_PRINTABLE) &&
		(item.char_code <= LAST_PRINTABLE);
	assign font_wr    = item_beat && (item.kind == KIND_FONT) &&
		(item.font_index < 13'(FONT_DEPTH));

	always_comb begin
		cmd.home    = item_beat && (item.kind == KIND_START);
		cmd.newline = item_beat && (item.kind == KIND_CHAR) && (item.char_code == NEWLINE_CODE);
		cmd.draw    = item_beat && (item.kind == KIND_CHAR) && printable;
		cmd.glyph   = 7'(item.char_code - FIRST_PRINTABLE);
	end

	sgb_walk u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.issue_ok (issue_ok),
		.idle     (walk_idle),
		.req      (req)
	);

	sgb_font_mem u_font (
		.clk     (clk),
		.wr_en   (font_wr),
		.wr_addr (item.font_index),
		.wr_data (item.font_pixel),
		.rd_en   (req.valid),
		.rd_addr (req.src),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rd_valid_s1 <= 1'b0;
		else
			rd_valid_s1 <= req.valid;
	end

	always_ff @(posedge clk) begin
		frame_s1 <= req.frame;
		last_s1  <= req.last;
	end

	// credit: a read issued now passes the read register before it lands in the queue; only issue
	// when at most one entry stays queued or in flight after this cycle's pop
	assign pop       = q_valid_q[0] && pix_ready;
	assign occupancy = {2'b0, q_valid_q[0]} + {2'b0, q_valid_q[1]} + {2'b0, rd_valid_s1}
		- {2'b0, pop};
	assign issue_ok  = (occupancy <= 3'd1);

	always_comb begin
		q_new.frame_address = frame_s1;
		q_new.pixel_value   = rd_data;
		q_new.last_write    = last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_valid_q <= '0;
		end else begin
			priority if (pop && rd_valid_s1) begin
				q_valid_q <= q_valid_q;
			end else if (pop) begin
				q_valid_q <= {1'b0, q_valid_q[1]};
			end else if (rd_valid_s1) begin
				q_valid_q <= {q_valid_q[0], 1'b1};
			end else begin
				q_valid_q <= q_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (pop && rd_valid_s1) begin
			if (q_valid_q[1]) begin
				q_head_q <= q_tail_q;
				q_tail_q <= q_new;
			end else begin
				q_head_q <= q_new;
			end
		end else if (pop) begin
			q_head_q <= q_tail_q;
		end else if (rd_valid_s1) begin
			if (q_valid_q[0])
				q_tail_q <= q_new;
			else
				q_head_q <= q_new;
		end else begin
			q_head_q <= q_head_q;
		end
	end

	assign pix_valid = q_valid_q[0];
	assign pix       = q_head_q;

endmodule

`default_nettype wire

// ----- rtl/sgb_checker.sv -----
// Port-level checker for the scaled glyph text blitter, bound to the top level.
// Depends on sgb_pkg and scaled_glyph_text_blitter.
`default_nettype none

module sgb_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           cfg_valid,
	input wire logic           cfg_ready,
	input wire logic           item_valid,
	input wire logic           item_ready,
	input wire sgb_pkg::item_t item,
	input wire logic           pix_valid,
	input wire logic           pix_ready,
	input wire sgb_pkg::pix_t  pix
);
	import sgb_pkg::*;

	logic draw_beat;

	assign draw_beat = item_valid && item_ready && (item.kind == KIND_CHAR) &&
		(item.char_code >= FIRST_PRINTABLE) && (item.char_code <= LAST_PRINTABLE);

	// a drawn character always holds off the next item for its setup
	a_draw_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		draw_beat |=> !item_ready)
		else $error("item_ready high right after a drawn character");

	// every other item leaves item_ready high for the next item
	a_short_items: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && !draw_beat) |=> item_ready)
		else $error("non-drawing item held off the next item");

	// a stalled pixel beat holds
	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && !pix_ready) |=> (pix_valid && $stable(pix)))
		else $error("pixel beat changed while stalled");

	// config writes are always taken
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");

endmodule

bind scaled_glyph_text_blitter sgb_checker u_sgb_checker (.*);

`default_nettype wire
